FILE: hdl/tmp_pkg.sv
// ----------------------------------------------------------------------------
// tmp_pkg
// Shared types, codes and helpers for the trapezoid move planner.
// ----------------------------------------------------------------------------
package tmp_pkg;

  localparam int unsigned FracBits    = 16;
  localparam int unsigned DirBits     = 30;
  localparam int unsigned FeedDivisor = 60;

  // feed / 60 as a reciprocal multiply, exact for every 32-bit feed
  localparam logic [31:0] FeedRecip = 32'h8888_8889;
  localparam int unsigned FeedShift = 37;

  localparam logic [31:0] MaxVelocityReset = 32'd19660800;
  localparam logic [31:0] MaxAccelReset    = 32'd196608000;

  localparam logic [1:0] CFG_MAX_VELOCITY = 2'd0;
  localparam logic [1:0] CFG_MAX_ACCEL    = 2'd1;

  localparam logic [1:0] OP_LINEAR  = 2'd0;
  localparam logic [1:0] OP_HOME    = 2'd1;
  localparam logic [1:0] OP_SET_POS = 2'd2;
  localparam logic [1:0] OP_IGNORE  = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic               has_x;
    logic               has_y;
    logic               has_z;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic signed [31:0] z_value;
    logic               has_feed;
    logic [31:0]        feed_value;
    logic               bare_x;
    logic               bare_y;
    logic               bare_z;
  } in_t;

  typedef struct packed {
    logic               move_valid;
    logic [47:0]        start_time;
    logic [31:0]        accel_time;
    logic [31:0]        cruise_time;
    logic [31:0]        decel_time;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [31:0]        cruise_velocity;
  } out_t;

  typedef enum logic [4:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_SQ_X,
    CMD_SQ_Y,
    CMD_SQ_Z,
    CMD_LEN_GO,
    CMD_LEN_CAP,
    CMD_LA_MUL,
    CMD_V2_MUL,
    CMD_DECIDE,
    CMD_PK_GO,
    CMD_V2A_GO,
    CMD_V2A_CAP,
    CMD_CT_GO,
    CMD_CT_CAP,
    CMD_AT_GO,
    CMD_AT_CAP,
    CMD_DX_GO,
    CMD_DX_CAP,
    CMD_DY_GO,
    CMD_DY_CAP,
    CMD_DZ_GO,
    CMD_DZ_CAP,
    CMD_FINISH
  } cmd_e;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic len_zero;
    logic triangle;
  } status_t;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    return (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [32:0] mag33(input logic [32:0] d);
    return d[32] ? (33'd0 - d) : d;
  endfunction

endpackage

FILE: hdl/trapezoid_move_planner.sv
// Home, set-position and ignored requests go from acceptance straight to the
// finish state; a zero-length move ends after the length root, and a move
// runs through the shared one-bit-per-cycle divider (four to six quotients)
// and the square-root unit. One request at a time; the next is taken once
// the result sits in the output register. Reset clears position, feed, time.
// ----------------------------------------------------------------------------
// trapezoid_move_planner
// Plans one straight move per motion request with a trapezoid or triangle
// velocity profile, and keeps position, feed rate and a time cursor.
// ----------------------------------------------------------------------------
module trapezoid_move_planner (
  input  logic          clk_i,
  input  logic          rst_ni,
  // request channel
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tmp_pkg::in_t  in_data_i,
  // result channel
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tmp_pkg::out_t out_data_o,
  // register writes
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);

  tmp_pkg::cmd_e    cmd;
  tmp_pkg::status_t status;

  // registers are always writable; writes land only while idle by contract
  assign cfg_ready_o = 1'b1;

  // sequencer: one state per datapath step, waits on the iterative units
  tmp_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_op_i       (in_data_i.operation),
    .out_ready_i   (out_ready_i),
    .status_i      (status),
    .in_ready_o    (in_ready_o),
    .out_valid_o   (out_valid_o),
    .cmd_o         (cmd)
  );

  // datapath: kept state, squares and products, divider, square root,
  // and the output register; a new feed is converted on acceptance
  tmp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_i        (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .status_o    (status),
    .out_o       (out_data_o)
  );

endmodule

FILE: hdl/tmp_div.sv
// ----------------------------------------------------------------------------
// tmp_div
// Restoring divider, 64-bit dividend by 34-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module tmp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [33:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [33:0] rem_q, dvs_q;
  logic [63:0] quo_q;
  logic [34:0] trial, diff;
  logic        fits;

  always_comb begin
    trial = {rem_q, quo_q[63]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == '1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[33:0] : trial[33:0];
      quo_q <= {quo_q[62:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: hdl/tmp_sqrt.sv
// ----------------------------------------------------------------------------
// tmp_sqrt
// Digit-by-digit integer square root, 68-bit radicand, one bit per cycle.
// ----------------------------------------------------------------------------
module tmp_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [67:0] radicand_i,
  output logic        done_o,
  output logic [33:0] root_o
);

  localparam int unsigned SqrtSteps = 34;

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [67:0] rad_q;
  logic [37:0] rem_q;
  logic [33:0] root_q;
  logic [37:0] trial, test;
  logic        fits;

  always_comb begin
    trial = {rem_q[35:0], rad_q[67:66]};
    test  = {2'b00, root_q, 2'b01};
    fits  = (trial >= test);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(SqrtSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[65:0], 2'b00};
      rem_q  <= fits ? (trial - test) : trial;
      root_q <= {root_q[32:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: hdl/tmp_dp.sv
// ----------------------------------------------------------------------------
// tmp_dp
// Planner datapath: kept state, multiplier, shared divider and root unit.
// ----------------------------------------------------------------------------
module tmp_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tmp_pkg::cmd_e    cmd_i,
  input  tmp_pkg::in_t     in_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i,
  output tmp_pkg::status_t status_o,
  output tmp_pkg::out_t    out_o
);

  // kept state and configuration
  logic [31:0] max_vel_q, max_acc_q, feed_q;
  logic        feed_seen_q, move_q;
  logic [31:0] pos_x_q, pos_y_q, pos_z_q;
  logic [47:0] time_q;

  // per-move working registers
  logic [31:0] tx_q, ty_q, tz_q;
  logic [32:0] dx_q, dy_q, dz_q;
  logic [67:0] prod_q, ss_q, la_q;
  logic [33:0] len_q, cd_q;
  logic [31:0] v_q, at_q, ct_q, dirx_q, diry_q, dirz_q;
  logic [63:0] v2_q;
  logic        tri_q;
  tmp_pkg::out_t out_q, out_d;

  logic [32:0] mx, my, mz;
  logic [33:0] mul_a, mul_b;
  logic [31:0] a_eff, v_comb, feed_eff;
  logic        sel_x, sel_y, sel_z, any_has, any_bare;
  logic [31:0] ntx, nty, ntz;
  logic [63:0] feed_prod;
  logic [31:0] feed_div;

  logic        div_start, div_done, sqrt_start, sqrt_done;
  logic [63:0] div_dividend, div_q;
  logic [33:0] div_divisor, root;
  logic [67:0] sqrt_rad;

  always_comb begin
    mx       = tmp_pkg::mag33(dx_q);
    my       = tmp_pkg::mag33(dy_q);
    mz       = tmp_pkg::mag33(dz_q);
    a_eff    = (max_acc_q == 32'd0) ? 32'd1 : max_acc_q;
    feed_eff = feed_seen_q ? feed_q : max_vel_q;
    v_comb   = (feed_eff > max_vel_q) ? max_vel_q : feed_eff;
    any_has  = in_i.has_x | in_i.has_y | in_i.has_z;
    any_bare = in_i.bare_x | in_i.bare_y | in_i.bare_z;
    sel_x    = any_has ? in_i.has_x : (any_bare ? in_i.bare_x : 1'b1);
    sel_y    = any_has ? in_i.has_y : (any_bare ? in_i.bare_y : 1'b1);
    sel_z    = any_has ? in_i.has_z : (any_bare ? in_i.bare_z : 1'b1);
    ntx      = in_i.has_x ? in_i.x_value : pos_x_q;
    nty      = in_i.has_y ? in_i.y_value : pos_y_q;
    ntz      = in_i.has_z ? in_i.z_value : pos_z_q;
    // mm/min to mm/s, taken while the request is still on the bus
    feed_prod = 64'(in_i.feed_value) * 64'(tmp_pkg::FeedRecip);
    feed_div  = 32'(feed_prod >> tmp_pkg::FeedShift);
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i)
      tmp_pkg::CMD_SQ_X:   begin mul_a = {1'b0, mx}; mul_b = {1'b0, mx}; end
      tmp_pkg::CMD_SQ_Y:   begin mul_a = {1'b0, my}; mul_b = {1'b0, my}; end
      tmp_pkg::CMD_SQ_Z:   begin mul_a = {1'b0, mz}; mul_b = {1'b0, mz}; end
      tmp_pkg::CMD_LA_MUL: begin mul_a = len_q; mul_b = 34'(a_eff); end
      tmp_pkg::CMD_V2_MUL: begin mul_a = 34'(v_q); mul_b = 34'(v_q); end
      default: ;
    endcase
  end

  // divider and root unit operand select
  always_comb begin
    div_start    = 1'b1;
    div_dividend = '0;
    div_divisor  = '0;
    case (cmd_i)
      tmp_pkg::CMD_V2A_GO: begin
        div_dividend = v2_q;
        div_divisor  = 34'(a_eff);
      end
      tmp_pkg::CMD_CT_GO: begin
        div_dividend = 64'(cd_q) << tmp_pkg::FracBits;
        div_divisor  = 34'(v_q);
      end
      tmp_pkg::CMD_AT_GO: begin
        div_dividend = tri_q ? (64'(root[31:0]) << tmp_pkg::FracBits)
                             : (64'(v_q) << tmp_pkg::FracBits);
        div_divisor  = 34'(a_eff);
      end
      tmp_pkg::CMD_DX_GO: begin
        div_dividend = 64'(mx) << tmp_pkg::DirBits;
        div_divisor  = len_q;
      end
      tmp_pkg::CMD_DY_GO: begin
        div_dividend = 64'(my) << tmp_pkg::DirBits;
        div_divisor  = len_q;
      end
      tmp_pkg::CMD_DZ_GO: begin
        div_dividend = 64'(mz) << tmp_pkg::DirBits;
        div_divisor  = len_q;
      end
      default: div_start = 1'b0;
    endcase
  end

  assign sqrt_start = (cmd_i == tmp_pkg::CMD_LEN_GO) || (cmd_i == tmp_pkg::CMD_PK_GO);
  assign sqrt_rad   = (cmd_i == tmp_pkg::CMD_PK_GO) ? la_q : (ss_q + prod_q);

  tmp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  tmp_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sqrt_rad),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  // kept state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_vel_q   <= tmp_pkg::MaxVelocityReset;
      max_acc_q   <= tmp_pkg::MaxAccelReset;
      feed_q      <= '0;
      feed_seen_q <= 1'b0;
      move_q      <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      pos_z_q     <= '0;
      time_q      <= '0;
    end else begin
      if (cfg_we_i && cfg_index_i == tmp_pkg::CFG_MAX_VELOCITY) begin
        max_vel_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == tmp_pkg::CFG_MAX_ACCEL) begin
        max_acc_q <= cfg_data_i;
      end
      case (cmd_i)
        tmp_pkg::CMD_LOAD: begin
          move_q <= 1'b0;
          if (in_i.operation == tmp_pkg::OP_HOME) begin
            if (sel_x) pos_x_q <= '0;
            if (sel_y) pos_y_q <= '0;
            if (sel_z) pos_z_q <= '0;
          end else if (in_i.operation == tmp_pkg::OP_SET_POS) begin
            if (in_i.has_x) pos_x_q <= in_i.x_value;
            if (in_i.has_y) pos_y_q <= in_i.y_value;
            if (in_i.has_z) pos_z_q <= in_i.z_value;
          end else if (in_i.operation == tmp_pkg::OP_LINEAR && in_i.has_feed) begin
            feed_q      <= feed_div;
            feed_seen_q <= 1'b1;
          end
        end
        tmp_pkg::CMD_LA_MUL: move_q <= 1'b1;
        tmp_pkg::CMD_FINISH: begin
          if (move_q) begin
            time_q  <= time_q + 48'(at_q) + 48'(ct_q) + 48'(at_q);
            pos_x_q <= tx_q;
            pos_y_q <= ty_q;
            pos_z_q <= tz_q;
          end
        end
        default: ;
      endcase
    end
  end

  // result assembly
  always_comb begin
    out_d = '0;
    if (move_q) begin
      out_d.move_valid      = 1'b1;
      out_d.start_time      = time_q;
      out_d.accel_time      = at_q;
      out_d.cruise_time     = ct_q;
      out_d.decel_time      = at_q;
      out_d.start_x         = pos_x_q;
      out_d.start_y         = pos_y_q;
      out_d.start_z         = pos_z_q;
      out_d.dir_x           = dirx_q;
      out_d.dir_y           = diry_q;
      out_d.dir_z           = dirz_q;
      out_d.cruise_velocity = tri_q ? root[31:0] : v_q;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      tmp_pkg::CMD_LOAD: begin
        tx_q <= ntx;
        ty_q <= nty;
        tz_q <= ntz;
        dx_q <= {ntx[31], ntx} - {pos_x_q[31], pos_x_q};
        dy_q <= {nty[31], nty} - {pos_y_q[31], pos_y_q};
        dz_q <= {ntz[31], ntz} - {pos_z_q[31], pos_z_q};
      end
      tmp_pkg::CMD_SQ_X: prod_q <= mul_a * mul_b;
      tmp_pkg::CMD_SQ_Y: begin
        ss_q   <= prod_q;
        prod_q <= mul_a * mul_b;
      end
      tmp_pkg::CMD_SQ_Z: begin
        ss_q   <= ss_q + prod_q;
        prod_q <= mul_a * mul_b;
      end
      tmp_pkg::CMD_LEN_CAP: len_q <= root;
      tmp_pkg::CMD_LA_MUL: begin
        v_q    <= v_comb;
        prod_q <= mul_a * mul_b;
      end
      tmp_pkg::CMD_V2_MUL: begin
        la_q   <= prod_q;
        prod_q <= mul_a * mul_b;
      end
      tmp_pkg::CMD_DECIDE: begin
        tri_q <= status_o.triangle;
        v2_q  <= prod_q[63:0];
        ct_q  <= '0;
      end
      tmp_pkg::CMD_V2A_CAP: cd_q <= len_q - div_q[33:0];
      tmp_pkg::CMD_CT_CAP:
        ct_q <= (v_q == 32'd0) ? 32'hFFFF_FFFF : tmp_pkg::sat32(div_q);
      tmp_pkg::CMD_AT_CAP: at_q <= tmp_pkg::sat32(div_q);
      tmp_pkg::CMD_DX_CAP: dirx_q <= dx_q[32] ? (32'd0 - div_q[31:0]) : div_q[31:0];
      tmp_pkg::CMD_DY_CAP: diry_q <= dy_q[32] ? (32'd0 - div_q[31:0]) : div_q[31:0];
      tmp_pkg::CMD_DZ_CAP: dirz_q <= dz_q[32] ? (32'd0 - div_q[31:0]) : div_q[31:0];
      tmp_pkg::CMD_FINISH: out_q <= out_d;
      default: ;
    endcase
  end

  always_comb begin
    status_o.div_done  = div_done;
    status_o.sqrt_done = sqrt_done;
    status_o.len_zero  = (root == 34'd0);
    status_o.triangle  = (la_q <= prod_q);
  end

  assign out_o = out_q;

endmodule

FILE: hdl/tmp_ctrl.sv
// ----------------------------------------------------------------------------
// tmp_ctrl
// Planner sequencer: steps the datapath through one command.
// ----------------------------------------------------------------------------
module tmp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       in_op_i,
  input  logic             out_ready_i,
  input  tmp_pkg::status_t status_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output tmp_pkg::cmd_e    cmd_o
);

  typedef enum logic [23:0] {
    S_IDLE  = 24'h000001,
    S_SQX   = 24'h000002,
    S_SQY   = 24'h000004,
    S_SQZ   = 24'h000008,
    S_LEN   = 24'h000010,
    S_LENW  = 24'h000020,
    S_LAM   = 24'h000040,
    S_V2M   = 24'h000080,
    S_DEC   = 24'h000100,
    S_PK    = 24'h000200,
    S_PKW   = 24'h000400,
    S_V2A   = 24'h000800,
    S_V2AW  = 24'h001000,
    S_CT    = 24'h002000,
    S_CTW   = 24'h004000,
    S_AT    = 24'h008000,
    S_ATW   = 24'h010000,
    S_DX    = 24'h020000,
    S_DXW   = 24'h040000,
    S_DY    = 24'h080000,
    S_DYW   = 24'h100000,
    S_DZ    = 24'h200000,
    S_DZW   = 24'h400000,
    S_DONE  = 24'h800000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   finish;

  always_comb begin
    state_d = state_q;
    cmd_o   = tmp_pkg::CMD_IDLE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o = tmp_pkg::CMD_LOAD;
          if (in_op_i != tmp_pkg::OP_LINEAR) state_d = S_DONE;
          else                               state_d = S_SQX;
        end
      end
      S_SQX: begin cmd_o = tmp_pkg::CMD_SQ_X; state_d = S_SQY; end
      S_SQY: begin cmd_o = tmp_pkg::CMD_SQ_Y; state_d = S_SQZ; end
      S_SQZ: begin cmd_o = tmp_pkg::CMD_SQ_Z; state_d = S_LEN; end
      S_LEN: begin cmd_o = tmp_pkg::CMD_LEN_GO; state_d = S_LENW; end
      S_LENW: begin
        if (status_i.sqrt_done) begin
          cmd_o   = tmp_pkg::CMD_LEN_CAP;
          state_d = status_i.len_zero ? S_DONE : S_LAM;
        end
      end
      S_LAM: begin cmd_o = tmp_pkg::CMD_LA_MUL; state_d = S_V2M; end
      S_V2M: begin cmd_o = tmp_pkg::CMD_V2_MUL; state_d = S_DEC; end
      S_DEC: begin
        cmd_o   = tmp_pkg::CMD_DECIDE;
        state_d = status_i.triangle ? S_PK : S_V2A;
      end
      S_PK:  begin cmd_o = tmp_pkg::CMD_PK_GO; state_d = S_PKW; end
      S_PKW: if (status_i.sqrt_done) state_d = S_AT;
      S_V2A: begin cmd_o = tmp_pkg::CMD_V2A_GO; state_d = S_V2AW; end
      S_V2AW: begin
        if (status_i.div_done) begin
          cmd_o = tmp_pkg::CMD_V2A_CAP; state_d = S_CT;
        end
      end
      S_CT: begin cmd_o = tmp_pkg::CMD_CT_GO; state_d = S_CTW; end
      S_CTW: begin
        if (status_i.div_done) begin
          cmd_o = tmp_pkg::CMD_CT_CAP; state_d = S_AT;
        end
      end
      S_AT: begin cmd_o = tmp_pkg::CMD_AT_GO; state_d = S_ATW; end
      S_ATW: begin
        if (status_i.div_done) begin
          cmd_o = tmp_pkg::CMD_AT_CAP; state_d = S_DX;
        end
      end
      S_DX: begin cmd_o = tmp_pkg::CMD_DX_GO; state_d = S_DXW; end
      S_DXW: begin
        if (status_i.div_done) begin
          cmd_o = tmp_pkg::CMD_DX_CAP; state_d = S_DY;
        end
      end
      S_DY: begin cmd_o = tmp_pkg::CMD_DY_GO; state_d = S_DYW; end
      S_DYW: begin
        if (status_i.div_done) begin
          cmd_o = tmp_pkg::CMD_DY_CAP; state_d = S_DZ;
        end
      end
      S_DZ: begin cmd_o = tmp_pkg::CMD_DZ_GO; state_d = S_DZW; end
      S_DZW: begin
        if (status_i.div_done) begin
          cmd_o = tmp_pkg::CMD_DZ_CAP; state_d = S_DONE;
        end
      end
      S_DONE: begin
        // output slot free, or being emptied this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o   = tmp_pkg::CMD_FINISH;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign finish      = (cmd_o == tmp_pkg::CMD_FINISH);
  assign out_valid_d = finish | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
